@@ rtl/bstk_pkg.sv @@
// Shared constants and types for the byte stack with value purge.
// No dependencies; every other rtl file imports this package.
package bstk_pkg;

   localparam int Depth = 1024;
   localparam int AddrW = $clog2(Depth);
   localparam int CntW  = 11;

   typedef logic [1:0]      cmd_type;
   typedef logic [1:0]      status_type;
   typedef logic [7:0]      byte_type;
   typedef logic [AddrW-1:0] addr_type;
   typedef logic [CntW-1:0]  count_type;

   localparam cmd_type CMD_PUSH  = 2'd0;
   localparam cmd_type CMD_POP   = 2'd1;
   localparam cmd_type CMD_PURGE = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   localparam count_type FullLevel = CntW'(Depth);

   // one access request to the stack memory
   typedef struct packed {
      logic     we;
      addr_type waddr;
      byte_type wdata;
      logic     re;
      addr_type raddr;
   } ram_req_type;

   // finished result offered by the sequencer
   typedef struct packed {
      logic       valid;
      byte_type   pop_value;
      status_type status;
      count_type  entry_count;
   } res_type;

endpackage

@@ rtl/bstk_req_if.sv @@
// Command channel: valid/ready handshake carrying one command word.
// Depends on bstk_pkg.
interface bstk_req_if;
   import bstk_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  cmd;
   byte_type value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

@@ rtl/bstk_rsp_if.sv @@
// Result channel: valid/ready handshake carrying one result word.
// Depends on bstk_pkg.
interface bstk_rsp_if;
   import bstk_pkg::*;

   logic       valid;
   logic       ready;
   byte_type   pop_value;
   status_type status;
   count_type  entry_count;

   modport source (output valid, output pop_value, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input pop_value, input status, input entry_count,
                   output ready);
endinterface

@@ rtl/bstk_ram.sv @@
// Stack storage: one write port, one read port with registered read data.
// Depends on bstk_pkg.
module bstk_ram (
   input  logic                   clock,
   input  bstk_pkg::ram_req_type  ram_req,
   output bstk_pkg::byte_type     rdata
);
   import bstk_pkg::*;

   byte_type store_ff [Depth];
   byte_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         store_ff[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rdata_ff <= store_ff[ram_req.raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/bstk_seq.sv @@
// Command sequencer: drives the stack memory, walks it for a purge and
// compacts in place through one shared compare. Depends on bstk_pkg.
module bstk_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bstk_pkg::cmd_type     req_cmd,
   input  bstk_pkg::byte_type    req_value,
   output bstk_pkg::ram_req_type ram_req,
   input  bstk_pkg::byte_type    ram_rdata,
   output bstk_pkg::res_type     res,
   input  logic                  res_take
);
   import bstk_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE     = 4'b0001,
      S_POP_WAIT = 4'b0010,
      S_SCAN     = 4'b0100,
      S_RESULT   = 4'b1000
   } state_type;

   state_type  state_ff,  state_in;
   count_type  fill_ff,   fill_in;
   count_type  rd_ff,     rd_in;
   count_type  wr_ff,     wr_in;
   logic       pend_ff,   pend_in;
   byte_type   victim_ff, victim_in;
   byte_type   pop_ff,    pop_in;
   status_type status_ff, status_in;

   count_type fill_dec;
   logic      keep;

   assign fill_dec = fill_ff - count_type'(1);
   // shared compare: does the word just read survive the purge
   assign keep     = (ram_rdata != victim_ff);

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      pend_in   = pend_ff;
      victim_in = victim_ff;
      pop_in    = pop_ff;
      status_in = status_ff;
      ram_req   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pop_in    = '0;
               status_in = ST_OK;
               state_in  = S_RESULT;
               case (req_cmd)
                  CMD_PUSH: begin
                     if (fill_ff == FullLevel) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = fill_ff[AddrW-1:0];
                        ram_req.wdata = req_value;
                        fill_in       = fill_ff + count_type'(1);
                     end
                  end
                  CMD_POP: begin
                     if (fill_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = fill_dec[AddrW-1:0];
                        fill_in       = fill_dec;
                        state_in      = S_POP_WAIT;
                     end
                  end
                  CMD_PURGE: begin
                     victim_in = req_value;
                     rd_in     = '0;
                     wr_in     = '0;
                     pend_in   = 1'b0;
                     state_in  = S_SCAN;
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_POP_WAIT: begin
            pop_in   = ram_rdata;
            state_in = S_RESULT;
         end
         S_SCAN: begin
            // issue next read, compare the previous one
            if (rd_ff != fill_ff) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = rd_ff[AddrW-1:0];
               rd_in         = rd_ff + count_type'(1);
               pend_in       = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && keep) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = wr_ff[AddrW-1:0];
               ram_req.wdata = ram_rdata;
               wr_in         = wr_ff + count_type'(1);
            end
            if (rd_ff == fill_ff && !pend_ff) begin
               fill_in  = wr_ff;
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
      rd_ff     <= rd_in;
      wr_ff     <= wr_in;
      victim_ff <= victim_in;
      pop_ff    <= pop_in;
      status_ff <= status_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign res.valid       = (state_ff == S_RESULT);
   assign res.pop_value   = pop_ff;
   assign res.status      = status_ff;
   assign res.entry_count = fill_ff;
endmodule

@@ rtl/byte_stack_with_value_purge_top.sv @@
// Byte stack with value purge: top level with the result output register.
// Depends on bstk_pkg, bstk_req_if, bstk_rsp_if, bstk_seq and bstk_ram.
//
// Usage
//   req_chan carries one command word: cmd (push, pop, purge) and value.
//   rsp_chan returns exactly one word per command: pop_value, status and
//   entry_count, the number of bytes held after the command.
//   A word is taken on a rising edge with valid and ready both high.
// Timing
//   One command at a time; ready is high only while the sequencer idles.
//   Push, error and no-op go straight to the result state. Pop waits in
//   S_POP_WAIT for the registered memory read. Purge walks over every
//   stored byte through the single read port, one a cycle.
// Stall
//   A finished result sits in the output register; the next command is
//   still accepted and runs, and its result waits in the sequencer until
//   the output register frees up.
// Reset
//   Synchronous, active high: stack empty, no result pending. The memory
//   is not cleared; only entries below the fill level are ever read.
module byte_stack_with_value_purge_top (
   input logic       clock,
   input logic       reset,
   bstk_req_if.sink   req_chan,
   bstk_rsp_if.source rsp_chan
);
   import bstk_pkg::*;

   ram_req_type ram_req;
   byte_type    ram_rdata;
   res_type     res;
   logic        res_take;

   logic       rsp_valid_ff,  rsp_valid_in;
   byte_type   rsp_pop_ff;
   status_type rsp_status_ff;
   count_type  rsp_count_ff;

   bstk_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_cmd   (req_chan.cmd),
      .req_value (req_chan.value),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .res       (res),
      .res_take  (res_take)
   );

   bstk_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (ram_rdata)
   );

   // output slot is free when empty or being drained this cycle
   assign res_take     = res.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_pop_ff    <= res.pop_value;
         rsp_status_ff <= res.status;
         rsp_count_ff  <= res.entry_count;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pop_value   = rsp_pop_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for byte_stack_with_value_purge_top: push, pop, purge and no-op words.
// Depends on bstk_pkg, bstk_req_if, bstk_rsp_if and the rtl below the top level.
module testbench;
   import bstk_pkg::*;

   // Command code three has no name in the package; it is a no-op.
   localparam cmd_type CMD_NOOP   = 2'd3;
   localparam int      QuietLimit = 10000;   // cycles with no handshake before giving up
   localparam int      NumRows    = 25;
   localparam int      RandPerPhase = 135;
   localparam int      LevelCap   = 48;      // random part keeps the stack mostly shallow

   typedef struct packed {
      byte_type   pop_value;
      status_type status;
      count_type  entry_count;
   } rsp_word_type;

   // One directed word; typed rows carry their own expected result.
   typedef struct {
      cmd_type    cmd;
      byte_type   value;
      bit         typed;
      byte_type   want_pop;
      status_type want_status;
      count_type  want_count;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   bstk_req_if req_chan ();
   bstk_rsp_if rsp_chan ();

   byte_stack_with_value_purge_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Predictor state: own copy of the stack and its fill level.
   byte_type    stack_mem [Depth];
   int unsigned stack_level = 0;

   rsp_word_type pending_results [$];
   int           mismatch_count = 0;
   int           quiet_cycles   = 0;
   int           send_idle_pct  = 0;
   int           rsp_stall_pct  = 0;

   // Directed part: empty-stack errors, byte extremes, every command,
   // purge with several matches, with none, and of the only entry.
   stim_row_type directed_rows [NumRows] = '{
      '{CMD_POP,   8'h00, 1'b1, 8'h00, ST_EMPTY, 11'd0},
      '{CMD_PURGE, 8'h00, 1'b1, 8'h00, ST_OK,    11'd0},
      '{CMD_NOOP,  8'hFF, 1'b1, 8'h00, ST_OK,    11'd0},
      '{CMD_PUSH,  8'h00, 1'b1, 8'h00, ST_OK,    11'd1},
      '{CMD_PUSH,  8'hFF, 1'b1, 8'h00, ST_OK,    11'd2},
      '{CMD_POP,   8'h00, 1'b1, 8'hFF, ST_OK,    11'd1},
      '{CMD_POP,   8'hFF, 1'b1, 8'h00, ST_OK,    11'd0},
      '{CMD_POP,   8'h00, 1'b1, 8'h00, ST_EMPTY, 11'd0},
      '{CMD_PUSH,  8'h5A, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PUSH,  8'hA5, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PUSH,  8'h5A, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PUSH,  8'h80, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PUSH,  8'h5A, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PURGE, 8'h5A, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PURGE, 8'h33, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_NOOP,  8'h00, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_POP,   8'h00, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PUSH,  8'h01, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PUSH,  8'h01, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PURGE, 8'h01, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_POP,   8'h00, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_POP,   8'h00, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PUSH,  8'h7F, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_PURGE, 8'h7F, 1'b0, 8'h00, ST_OK,    11'd0},
      '{CMD_POP,   8'h00, 1'b1, 8'h00, ST_EMPTY, 11'd0}
   };

   // Applies one command to the predictor's stack and returns the result word.
   function automatic rsp_word_type stack_predict(input cmd_type c, input byte_type v);
      rsp_word_type r;
      int unsigned  kept;
      r = '0;
      r.status = ST_OK;
      case (c)
         CMD_PUSH: begin
            if (stack_level >= Depth) begin
               r.status = ST_FULL;
            end else begin
               stack_mem[stack_level] = v;
               stack_level++;
            end
         end
         CMD_POP: begin
            if (stack_level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               stack_level--;
               r.pop_value = stack_mem[stack_level];
            end
         end
         CMD_PURGE: begin
            // compact survivors downwards, order kept
            kept = 0;
            for (int rd = 0; rd < stack_level; rd++) begin
               if (stack_mem[rd] != v) begin
                  stack_mem[kept] = stack_mem[rd];
                  kept++;
               end
            end
            stack_level = kept;
         end
         default: ;   // no-op code
      endcase
      r.entry_count = count_type'(stack_level);
      return r;
   endfunction

   function automatic void report_mismatch(input string msg);
      if (mismatch_count < 10)
         $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endfunction

   // Offers one command word, idling first at the sender's rate. Valid is
   // left high after acceptance so back-to-back words need no extra edge;
   // the expectation is queued at the acceptance edge.
   task automatic send_word(input cmd_type c, input byte_type v, input bit typed,
                            input rsp_word_type typed_want);
      rsp_word_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= c;
      req_chan.value <= v;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      predicted = stack_predict(c, v);
      pending_results.push_back(typed ? typed_want : predicted);
   endtask

   // Random word: pushes and pops balanced around a shallow level, purges
   // mostly aimed at a byte that is actually held, a few no-ops.
   task automatic send_random();
      int       roll;
      int       push_cut;
      cmd_type  c;
      byte_type v;
      roll     = $urandom_range(99);
      v        = byte_type'($urandom_range(255));
      push_cut = (stack_level > LevelCap) ? 36 : 58;
      if (roll < 4) begin
         c = CMD_NOOP;
      end else if (roll < 18) begin
         c = CMD_PURGE;
         if (stack_level != 0 && $urandom_range(3) != 0)
            v = stack_mem[$urandom_range(stack_level - 1)];
      end else if (roll < push_cut) begin
         c = CMD_PUSH;
      end else begin
         c = CMD_POP;
      end
      send_word(c, v, 1'b0, '0);
   endtask

   // Fill to the top, knock on the full stack, then purge the filled bytes away.
   // Fill bytes are drawn from four values so four purges clear them; a fifth takes the FF.
   task automatic fill_and_purge();
      while (stack_level < Depth)
         send_word(CMD_PUSH, byte_type'($urandom_range(3)), 1'b0, '0);
      repeat (3)
         send_word(CMD_PUSH, 8'hEE, 1'b1, '{8'h00, ST_FULL, FullLevel});
      send_word(CMD_POP, 8'h00, 1'b0, '0);
      send_word(CMD_PUSH, 8'hFF, 1'b0, '0);
      send_word(CMD_PURGE, 8'hC3, 1'b0, '0);   // full walk of a full stack
      for (int b = 3; b >= 0; b--)
         send_word(CMD_PURGE, byte_type'(b), 1'b0, '0);
      send_word(CMD_PURGE, 8'hFF, 1'b0, '0);
   endtask

   task automatic drain_results();
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Result side: ready toggles at the stall rate of the current phase.
   always @(posedge clock)
      rsp_chan.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);

   // Checker: each accepted result word against the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.pop_value, rsp_chan.status, rsp_chan.entry_count};
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word pop=%02h st=%0d cnt=%0d",
                                      got.pop_value, got.status, got.entry_count));
         end else begin
            want = pending_results.pop_front();
            if (got.pop_value !== want.pop_value || got.status !== want.status ||
                got.entry_count !== want.entry_count)
               report_mismatch($sformatf(
                  "exp pop=%02h st=%0d cnt=%0d, got pop=%02h st=%0d cnt=%0d",
                  want.pop_value, want.status, want.entry_count,
                  got.pop_value, got.status, got.entry_count));
         end
      end
   end

   // Watchdog: a purge of a full stack walks every stored byte with no handshake,
   // so the limit leaves a wide margin over that plus the longest stalls.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd   = CMD_PUSH;
      req_chan.value = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words, no idling on either side.
      for (int i = 0; i < NumRows; i++)
         send_word(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
                   '{directed_rows[i].want_pop, directed_rows[i].want_status,
                     directed_rows[i].want_count});

      // Random phases: none, sender idle, receiver stall, both. Between
      // phases the sender holds off until every result is back.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 72; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 72; end
            default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
         endcase
         repeat (RandPerPhase)
            send_random();
         if (phase == 2)
            fill_and_purge();
         req_chan.valid <= 1'b0;
         drain_results();
      end

      // Stray words would show up in this tail as unexpected results.
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
